@@ rtl/core/msge_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msge_pkg
// Shared types, codes and constants of the matrix stack geometry engine.
// ----------------------------------------------------------------------------
package msge_pkg;

  // one command item
  typedef struct packed {
    logic [3:0]         command;
    logic [1:0]         row;
    logic [1:0]         column;
    logic [1:0]         axis;
    logic signed [31:0] first_operand;
    logic signed [31:0] second_operand;
    logic signed [31:0] third_operand;
  } item_t;

  // one result item
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [2:0]         status;
  } result_t;

  typedef enum logic [3:0] {
    CMD_WR_TOP  = 4'd0,
    CMD_WR_OPND = 4'd1,
    CMD_PUSH    = 4'd2,
    CMD_POP     = 4'd3,
    CMD_POSTMUL = 4'd4,
    CMD_PREMUL  = 4'd5,
    CMD_ROT     = 4'd6,
    CMD_TRANSL  = 4'd7,
    CMD_SCALE   = 4'd8,
    CMD_SHEAR   = 4'd9,
    CMD_XFORM   = 4'd10,
    CMD_READ    = 4'd11
  } cmd_t;

  typedef enum logic [1:0] {
    AXIS_X   = 2'd0,
    AXIS_Y   = 2'd1,
    AXIS_Z   = 2'd2,
    AXIS_BAD = 2'd3
  } axis_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_BAD_AXIS  = 3'd3,
    ST_DIV_ZERO  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_COPY,
    S_MAC,
    S_DRAIN,
    S_WB,
    S_READ_WAIT,
    S_DIV_X,
    S_DIV_Y_START,
    S_DIV_Y,
    S_DONE
  } state_t;

  localparam logic signed [31:0] QONE    = 32'sh0001_0000;
  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  localparam int STEP_W = 7;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              init_wr;
    logic              elem_wr;
    logic              opnd_wr;
    logic              copy_rd;
    logic              copy_wr;
    logic              lvl_inc;
    logic              lvl_dec;
    logic              mac_issue;
    logic              wb_wr;
    logic              elem_rd;
    logic              rd_cap;
    logic              xf_sat;
    logic              div_start;
    logic              div_sel;
    logic              div_cap;
    logic              status_wr;
    status_t           status;
    logic              out_load;
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [3:0] command;
    logic       axis_bad;
    logic       full;
    logic       empty;
    logic       mac_busy;
    logic       div_done;
    logic       w_zero;
  } dp_stat_t;

endpackage

@@ rtl/core/matrix_stack_geometry_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_stack_geometry_engine
// Stack of 4x4 Q16.16 matrices with an operand matrix, element access,
// push and pop, matrix products, rotate, translate, scale, shear and a
// point transform with divide by w. One result per command.
//
//   channel  direction  signals                       transfer when
//   item     in         item_valid, item_stall, item  valid && !stall
//   result   out        result_valid, result_stall,   valid && !stall
//                       result
//
// One item at a time. Matrix commands run 64 multiplies on the single
// shared 32x32 multiplier, then write the 16 elements back to the matrix
// store. A point transform ends in two 48-step serial divides unless w
// is zero. After reset a pass writes the identity into level zero while
// item_stall stays high. A stalled result holds in the output register
// until taken.
// ----------------------------------------------------------------------------
module matrix_stack_geometry_engine #(
  parameter int STACK_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  msge_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output msge_pkg::result_t result
);

  msge_pkg::dp_cmd_t  cmd;
  msge_pkg::dp_stat_t stat;

  msge_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  msge_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .item_in (item),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

endmodule

@@ rtl/core/msge_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msge_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module msge_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/msge_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msge_div
// Serial Q16.16 divider: (num * 2^16) / den, one quotient bit per cycle,
// truncated toward zero and saturated to 32 bits. den must be nonzero.
// ----------------------------------------------------------------------------
module msge_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);

  localparam logic signed [31:0] SAT_MIN_L = msge_pkg::SAT_MIN;

  logic [47:0] dvd;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic        neg;
  logic        run;
  logic [5:0]  cnt;
  logic [31:0] num_mag;
  logic [31:0] den_mag;
  logic [32:0] trial;
  logic        qbit;
  logic [32:0] diff;

  assign num_mag = num[31] ? 32'(-num) : 32'(num);
  assign den_mag = den[31] ? 32'(-den) : 32'(den);
  assign trial   = {rem, dvd[47]};
  assign qbit    = (trial >= {1'b0, dsr});
  assign diff    = trial - {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == 6'd47);
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          run <= 1'b0;
        end
      end
    end
  end

  // restoring shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {num_mag, 16'h0000};
      rem <= '0;
      dsr <= den_mag;
      neg <= num[31] ^ den[31];
    end else if (run) begin
      rem <= qbit ? diff[31:0] : trial[31:0];
      dvd <= {dvd[46:0], qbit};
    end
  end

  // sign and saturate the magnitude quotient
  always_comb begin
    if (neg) begin
      if (dvd > 48'h0000_8000_0000) begin
        quo = SAT_MIN_L;
      end else begin
        quo = 32'(-dvd[31:0]);
      end
    end else begin
      if (dvd > 48'h0000_7fff_ffff) begin
        quo = msge_pkg::SAT_MAX;
      end else begin
        quo = dvd[31:0];
      end
    end
  end

endmodule

@@ rtl/core/msge_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msge_datapath
// Matrix store, operand matrix, stack level, shared multiply-accumulate
// pipeline, result scratch and the output register.
// ----------------------------------------------------------------------------
module msge_datapath #(
  parameter int STACK_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  msge_pkg::item_t    item_in,
  input  msge_pkg::dp_cmd_t  cmd,
  output msge_pkg::dp_stat_t stat,
  output msge_pkg::result_t  result
);

  localparam int LW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int AW    = LW + 4;
  localparam int DEPTH = STACK_DEPTH * 16;

  typedef struct packed {
    logic               neg;
    logic signed [31:0] val;
  } coef_t;

  msge_pkg::item_t    item;
  logic [LW-1:0]      level;
  logic [LW-1:0]      level_p1;
  logic signed [31:0] opnd [16];
  logic signed [31:0] tmp [16];
  logic [3:0]         cp_idx;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [31:0]        wdata;
  logic [AW-1:0]      raddr;
  logic [31:0]        rdata;
  logic signed [31:0] rd_s;

  logic [1:0]         mi;
  logic [1:0]         mj;
  logic [1:0]         mk;
  logic               is_xf;
  logic               is_pre;
  logic               is_post;
  logic [3:0]         top_idx;
  logic [3:0]         opnd_idx;
  coef_t              coef;

  logic               s1_valid;
  logic               s1_neg;
  logic               s1_first;
  logic               s1_last;
  logic [3:0]         s1_idx;
  logic signed [31:0] s1_coef;
  logic               s2_valid;
  logic               s2_neg;
  logic               s2_first;
  logic               s2_last;
  logic [3:0]         s2_idx;
  logic signed [63:0] s2_prod;
  logic signed [63:0] mul;
  logic signed [51:0] acc;
  logic signed [51:0] term;
  logic signed [51:0] acc_next;

  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic signed [31:0] res_z;
  msge_pkg::status_t  res_status;

  logic               div_done;
  logic signed [31:0] div_quo;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > 52'sd2147483647) begin
      r = msge_pkg::SAT_MAX;
    end else if (v < -52'sd2147483648) begin
      r = msge_pkg::SAT_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sign_sat(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v > 32'sd0) begin
      r = msge_pkg::SAT_MAX;
    end else if (v < 32'sd0) begin
      r = msge_pkg::SAT_MIN;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // coefficient of the right-hand matrix built from the item operands
  function automatic coef_t gen_coef(input logic [3:0] c, input logic [1:0] ax,
                                     input logic [1:0] k, input logic [1:0] j,
                                     input logic signed [31:0] a,
                                     input logic signed [31:0] b,
                                     input logic signed [31:0] t);
    coef_t r;
    r.neg = 1'b0;
    r.val = (k == j) ? msge_pkg::QONE : '0;
    case (msge_pkg::cmd_t'(c))
      msge_pkg::CMD_ROT: begin
        if (ax == msge_pkg::AXIS_X) begin
          if (j == 2'd1 && k == 2'd1) r.val = a;
          if (j == 2'd1 && k == 2'd2) begin r.val = b; r.neg = 1'b1; end
          if (j == 2'd2 && k == 2'd1) r.val = b;
          if (j == 2'd2 && k == 2'd2) r.val = a;
        end else if (ax == msge_pkg::AXIS_Y) begin
          if (j == 2'd0 && k == 2'd0) r.val = a;
          if (j == 2'd0 && k == 2'd2) r.val = b;
          if (j == 2'd2 && k == 2'd2) r.val = a;
          if (j == 2'd2 && k == 2'd0) begin r.val = b; r.neg = 1'b1; end
        end else begin
          if (j == 2'd0 && k == 2'd0) r.val = a;
          if (j == 2'd0 && k == 2'd1) begin r.val = b; r.neg = 1'b1; end
          if (j == 2'd1 && k == 2'd1) r.val = a;
          if (j == 2'd1 && k == 2'd0) r.val = b;
        end
      end
      msge_pkg::CMD_TRANSL: begin
        if (j == 2'd3) begin
          if (k == 2'd0) r.val = a;
          if (k == 2'd1) r.val = b;
          if (k == 2'd2) r.val = t;
        end
      end
      msge_pkg::CMD_SCALE: begin
        if (k == j && j == 2'd0) r.val = a;
        if (k == j && j == 2'd1) r.val = b;
        if (k == j && j == 2'd2) r.val = t;
      end
      msge_pkg::CMD_SHEAR: begin
        if (ax == msge_pkg::AXIS_X) begin
          if (j == 2'd0 && k == 2'd1) r.val = a;
          if (j == 2'd0 && k == 2'd2) r.val = b;
        end else if (ax == msge_pkg::AXIS_Y) begin
          if (j == 2'd1 && k == 2'd0) r.val = a;
          if (j == 2'd1 && k == 2'd2) r.val = b;
        end else begin
          if (j == 2'd2 && k == 2'd0) r.val = a;
          if (j == 2'd2 && k == 2'd1) r.val = b;
        end
      end
      msge_pkg::CMD_XFORM: begin
        r.val = msge_pkg::QONE;
        if (k == 2'd0) r.val = a;
        if (k == 2'd1) r.val = b;
        if (k == 2'd2) r.val = t;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // item register, operand matrix and stack level
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= item_in;
    end
    if (cmd.opnd_wr) begin
      opnd[{item.row, item.column}] <= item.first_operand;
    end
    cp_idx <= cmd.step[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (cmd.lvl_inc) begin
      level <= level_p1;
    end else if (cmd.lvl_dec) begin
      level <= level - LW'(1);
    end
  end

  assign level_p1 = level + LW'(1);

  // element indices of the current multiply step
  assign is_xf    = (item.command == msge_pkg::CMD_XFORM);
  assign is_pre   = (item.command == msge_pkg::CMD_PREMUL);
  assign is_post  = (item.command == msge_pkg::CMD_POSTMUL);
  assign mi       = is_xf ? cmd.step[3:2] : cmd.step[5:4];
  assign mj       = is_xf ? 2'd0 : cmd.step[3:2];
  assign mk       = cmd.step[1:0];
  assign top_idx  = is_pre ? {mk, mj} : {mi, mk};
  assign opnd_idx = is_pre ? {mi, mk} : {mk, mj};

  always_comb begin
    coef = gen_coef(item.command, item.axis, mk, mj, item.first_operand,
                    item.second_operand, item.third_operand);
    if (is_pre || is_post) begin
      coef.neg = 1'b0;
      coef.val = opnd[opnd_idx];
    end
  end

  // matrix store ports
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.init_wr) begin
      we    = 1'b1;
      waddr = {LW'(0), cmd.step[3:0]};
      wdata = (cmd.step[3:2] == cmd.step[1:0]) ? msge_pkg::QONE : '0;
    end else if (cmd.elem_wr) begin
      we    = 1'b1;
      waddr = {level, item.row, item.column};
      wdata = item.first_operand;
    end else if (cmd.copy_wr) begin
      we    = 1'b1;
      waddr = {level_p1, cp_idx};
      wdata = rdata;
    end else if (cmd.wb_wr) begin
      we    = 1'b1;
      waddr = {level, cmd.step[3:0]};
      wdata = tmp[cmd.step[3:0]];
    end
  end

  always_comb begin
    if (cmd.mac_issue) begin
      raddr = {level, top_idx};
    end else if (cmd.copy_rd) begin
      raddr = {level, cmd.step[3:0]};
    end else begin
      raddr = {level, item.row, item.column};
    end
  end

  msge_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_s = rdata;
  assign mul  = rd_s * s1_coef;

  // multiply-accumulate pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.mac_issue;
      s2_valid <= s1_valid;
    end
  end

  // multiply-accumulate pipeline payload
  always_ff @(posedge clk) begin
    s1_neg   <= coef.neg;
    s1_first <= (mk == 2'd0);
    s1_last  <= (mk == 2'd3);
    s1_idx   <= {mi, mj};
    s1_coef  <= coef.val;
    s2_neg   <= s1_neg;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_idx   <= s1_idx;
    s2_prod  <= mul;
    if (s2_valid) begin
      acc <= acc_next;
      if (s2_last) begin
        tmp[s2_idx] <= sat32(acc_next);
      end
    end
  end

  // product floored to Q16.16, sign extended into the accumulator
  assign term     = 52'($signed(s2_prod[63:16]));
  assign acc_next = (s2_first ? 52'sd0 : acc) + (s2_neg ? -term : term);

  msge_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (cmd.div_sel ? tmp[4] : tmp[0]),
    .den   (tmp[12]),
    .done  (div_done),
    .quo   (div_quo)
  );

  // result scratch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_x      <= '0;
      res_y      <= '0;
      res_z      <= '0;
      res_status <= msge_pkg::ST_OK;
    end else begin
      if (cmd.status_wr) begin
        res_status <= cmd.status;
      end
      if (cmd.rd_cap) begin
        res_x <= rdata;
      end
      if (cmd.xf_sat) begin
        res_x <= sign_sat(tmp[0]);
        res_y <= sign_sat(tmp[4]);
        res_z <= tmp[8];
      end
      if (cmd.div_start && !cmd.div_sel) begin
        res_z <= tmp[8];
      end
      if (cmd.div_cap) begin
        if (cmd.div_sel) begin
          res_y <= div_quo;
        end else begin
          res_x <= div_quo;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.out_x  <= res_x;
      result.out_y  <= res_y;
      result.out_z  <= res_z;
      result.status <= res_status;
    end
  end

  // status toward the controller
  assign stat.command  = item.command;
  assign stat.axis_bad = (item.axis == msge_pkg::AXIS_BAD);
  assign stat.full     = (level == LW'(STACK_DEPTH - 1));
  assign stat.empty    = (level == '0);
  assign stat.mac_busy = s1_valid | s2_valid;
  assign stat.div_done = div_done;
  assign stat.w_zero   = (tmp[12] == '0);

endmodule

@@ rtl/core/msge_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msge_ctrl
// Sequencer of the geometry engine: handshakes, step counter and the
// command strobes for the datapath.
// ----------------------------------------------------------------------------
module msge_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  output logic               result_valid,
  input  logic               result_stall,
  input  msge_pkg::dp_stat_t stat,
  output msge_pkg::dp_cmd_t  cmd
);

  msge_pkg::state_t             state;
  msge_pkg::state_t             state_next;
  logic [msge_pkg::STEP_W-1:0]  step;
  logic [msge_pkg::STEP_W-1:0]  step_next;
  logic [msge_pkg::STEP_W-1:0]  mac_last;

  assign item_stall = (state != msge_pkg::S_IDLE);
  assign mac_last   = (stat.command == msge_pkg::CMD_XFORM) ? 7'd15 : 7'd63;

  // state, step and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= msge_pkg::S_INIT;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // next state and datapath strobes
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.step   = step;
    unique case (state)
      msge_pkg::S_INIT: begin
        cmd.init_wr = 1'b1;
        step_next   = step + 7'd1;
        if (step == 7'd15) begin
          step_next  = '0;
          state_next = msge_pkg::S_IDLE;
        end
      end
      msge_pkg::S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = msge_pkg::S_DISPATCH;
        end
      end
      msge_pkg::S_DISPATCH: begin
        step_next  = '0;
        state_next = msge_pkg::S_DONE;
        case (msge_pkg::cmd_t'(stat.command))
          msge_pkg::CMD_WR_TOP:  cmd.elem_wr = 1'b1;
          msge_pkg::CMD_WR_OPND: cmd.opnd_wr = 1'b1;
          msge_pkg::CMD_PUSH: begin
            if (stat.full) begin
              cmd.status_wr = 1'b1;
              cmd.status    = msge_pkg::ST_OVERFLOW;
            end else begin
              state_next = msge_pkg::S_COPY;
            end
          end
          msge_pkg::CMD_POP: begin
            if (stat.empty) begin
              cmd.status_wr = 1'b1;
              cmd.status    = msge_pkg::ST_UNDERFLOW;
            end else begin
              cmd.lvl_dec = 1'b1;
            end
          end
          msge_pkg::CMD_POSTMUL, msge_pkg::CMD_PREMUL, msge_pkg::CMD_TRANSL,
          msge_pkg::CMD_SCALE, msge_pkg::CMD_XFORM: begin
            state_next = msge_pkg::S_MAC;
          end
          msge_pkg::CMD_ROT, msge_pkg::CMD_SHEAR: begin
            if (stat.axis_bad) begin
              cmd.status_wr = 1'b1;
              cmd.status    = msge_pkg::ST_BAD_AXIS;
            end else begin
              state_next = msge_pkg::S_MAC;
            end
          end
          msge_pkg::CMD_READ: begin
            cmd.elem_rd = 1'b1;
            state_next  = msge_pkg::S_READ_WAIT;
          end
          default: begin
          end
        endcase
      end
      msge_pkg::S_COPY: begin
        cmd.copy_rd = (step < 7'd16);
        cmd.copy_wr = (step != 7'd0);
        step_next   = step + 7'd1;
        if (step == 7'd16) begin
          cmd.lvl_inc = 1'b1;
          step_next   = '0;
          state_next  = msge_pkg::S_DONE;
        end
      end
      msge_pkg::S_MAC: begin
        cmd.mac_issue = 1'b1;
        step_next     = step + 7'd1;
        if (step == mac_last) begin
          step_next  = '0;
          state_next = msge_pkg::S_DRAIN;
        end
      end
      msge_pkg::S_DRAIN: begin
        if (!stat.mac_busy) begin
          if (stat.command != msge_pkg::CMD_XFORM) begin
            state_next = msge_pkg::S_WB;
          end else if (stat.w_zero) begin
            cmd.xf_sat    = 1'b1;
            cmd.status_wr = 1'b1;
            cmd.status    = msge_pkg::ST_DIV_ZERO;
            state_next    = msge_pkg::S_DONE;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = msge_pkg::S_DIV_X;
          end
        end
      end
      msge_pkg::S_WB: begin
        cmd.wb_wr = 1'b1;
        step_next = step + 7'd1;
        if (step == 7'd15) begin
          step_next  = '0;
          state_next = msge_pkg::S_DONE;
        end
      end
      msge_pkg::S_READ_WAIT: begin
        cmd.rd_cap = 1'b1;
        state_next = msge_pkg::S_DONE;
      end
      msge_pkg::S_DIV_X: begin
        if (stat.div_done) begin
          cmd.div_cap = 1'b1;
          state_next  = msge_pkg::S_DIV_Y_START;
        end
      end
      msge_pkg::S_DIV_Y_START: begin
        cmd.div_sel   = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = msge_pkg::S_DIV_Y;
      end
      msge_pkg::S_DIV_Y: begin
        cmd.div_sel = 1'b1;
        if (stat.div_done) begin
          cmd.div_cap = 1'b1;
          state_next  = msge_pkg::S_DONE;
        end
      end
      msge_pkg::S_DONE: begin
        if (!result_valid || !result_stall) begin
          cmd.out_load = 1'b1;
          state_next   = msge_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = msge_pkg::S_IDLE;
      end
    endcase
  end

endmodule
